>>> rtl/rbs_pkg.sv
// Package: shared widths, register indexes and types for the ray/box slab test.
package rbs_pkg;

    localparam int DW        = 32;
    localparam int FRAC_BITS = 16;
    localparam int NUM_AXES  = 3;
    localparam int IDX_W     = 3;

    localparam logic signed [DW-1:0] S32_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] S32_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef enum logic [IDX_W-1:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } t_reg_idx;

    // Per-axis side information that travels alongside the dividers
    typedef struct packed {
        logic                 zero;
        logic                 dneg;
        logic                 nlo;
        logic                 nhi;
        logic signed [DW-1:0] slo;
        logic signed [DW-1:0] shi;
    } t_axis_sb;

endpackage

>>> rtl/rbs_if.sv
// Interfaces: ray input, result output and configuration write channels.
interface rbs_ray_if;
    import rbs_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] origin_x;
    logic signed [DW-1:0] origin_y;
    logic signed [DW-1:0] origin_z;
    logic signed [DW-1:0] dir_x;
    logic signed [DW-1:0] dir_y;
    logic signed [DW-1:0] dir_z;
    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    output ready);
endinterface

interface rbs_res_if;
    import rbs_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic signed [DW-1:0] t_near;
    logic signed [DW-1:0] t_far;
    modport source (output valid, hit, t_near, t_far, input ready);
    modport sink   (input valid, hit, t_near, t_far, output ready);
endinterface

interface rbs_cfg_if;
    import rbs_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [DW-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/ray_box_slab_intersection.sv
// Top level: ray against axis-aligned box slab test, fully pipelined.
// From the accepting edge a ray passes stage A, the divider stages, stage P and the output register.
// Throughput: one ray per cycle while the pipe advances; six bit-per-stage dividers set the depth.
// The whole pipe advances together whenever the output register is empty or taken.
// Reset (synchronous, active low) clears all valid bits and loads an empty box.
// Configuration writes are always accepted; indexes beyond five are dropped.
module ray_box_slab_intersection
    import rbs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    rbs_cfg_if.sink    i_cfg,
    rbs_ray_if.sink    i_ray,
    rbs_res_if.source  o_res
);

    logic signed [DW-1:0] r_bmin [0:NUM_AXES-1];
    logic signed [DW-1:0] r_bmax [0:NUM_AXES-1];

    logic                 w_en;
    logic signed [DW-1:0] w_org [0:NUM_AXES-1];
    logic signed [DW-1:0] w_dir [0:NUM_AXES-1];

    // Stage A: differences
    logic                 r_a_vld;
    logic signed [DW:0]   r_a_dlo [0:NUM_AXES-1];
    logic signed [DW:0]   r_a_dhi [0:NUM_AXES-1];
    logic signed [DW-1:0] r_a_dir [0:NUM_AXES-1];

    // Divider operands and side information
    logic [DW-1:0]        w_nlo [0:NUM_AXES-1];
    logic [DW-1:0]        w_nhi [0:NUM_AXES-1];
    logic [DW-1:0]        w_den [0:NUM_AXES-1];
    t_axis_sb             w_sb  [0:NUM_AXES-1];
    logic [DW-1:0]        w_qlo [0:NUM_AXES-1];
    logic [DW-1:0]        w_qhi [0:NUM_AXES-1];
    logic                 w_olo [0:NUM_AXES-1];
    logic                 w_ohi [0:NUM_AXES-1];

    logic                 r_d_vld [0:DW];
    t_axis_sb             r_sb [0:DW][0:NUM_AXES-1];

    // Stage P: per-axis distances
    logic                 r_p_vld;
    logic signed [DW-1:0] r_ta [0:NUM_AXES-1];
    logic signed [DW-1:0] r_tb [0:NUM_AXES-1];
    logic signed [DW-1:0] n_ta [0:NUM_AXES-1];
    logic signed [DW-1:0] n_tb [0:NUM_AXES-1];

    // Output register
    logic                 r_o_vld;
    logic                 r_o_hit;
    logic signed [DW-1:0] r_o_near;
    logic signed [DW-1:0] r_o_far;
    logic signed [DW-1:0] n_near;
    logic signed [DW-1:0] n_far;

    function automatic logic signed [DW-1:0] sat_diff(input logic signed [DW:0] v);
        logic signed [DW-1:0] res;
        if (v[DW] != v[DW-1]) res = v[DW] ? S32_MIN : S32_MAX;
        else                  res = v[DW-1:0];
        return res;
    endfunction

    function automatic logic signed [DW-1:0] sign_quo(input logic [DW-1:0] q,
                                                      input logic ovf, input logic neg);
        logic signed [DW-1:0] res;
        if (neg) begin
            if (ovf || (q[DW-1] && (|q[DW-2:0]))) res = S32_MIN;
            else                                   res = -q;
        end else begin
            if (ovf || q[DW-1]) res = S32_MAX;
            else                res = q;
        end
        return res;
    endfunction

    function automatic logic [DW-1:0] mag(input logic signed [DW:0] v);
        logic signed [DW:0] a;
        a = v[DW] ? -v : v;
        return a[DW-1:0];
    endfunction

    // Advance the whole pipe when the output is free
    assign w_en        = !r_o_vld || o_res.ready;
    assign i_ray.ready = w_en;
    assign i_cfg.ready = 1'b1;

    assign w_org[0] = i_ray.origin_x;
    assign w_org[1] = i_ray.origin_y;
    assign w_org[2] = i_ray.origin_z;
    assign w_dir[0] = i_ray.dir_x;
    assign w_dir[1] = i_ray.dir_y;
    assign w_dir[2] = i_ray.dir_z;

    // Box registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_bmin[i] <= S32_MAX;
                r_bmax[i] <= S32_MIN;
            end
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_MIN_X: r_bmin[0] <= i_cfg.data;
                REG_MIN_Y: r_bmin[1] <= i_cfg.data;
                REG_MIN_Z: r_bmin[2] <= i_cfg.data;
                REG_MAX_X: r_bmax[0] <= i_cfg.data;
                REG_MAX_Y: r_bmax[1] <= i_cfg.data;
                REG_MAX_Z: r_bmax[2] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Stage A: form bound minus origin at full precision
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_a_dlo[i] <= {r_bmin[i][DW-1], r_bmin[i]} - {w_org[i][DW-1], w_org[i]};
                r_a_dhi[i] <= {r_bmax[i][DW-1], r_bmax[i]} - {w_org[i][DW-1], w_org[i]};
                r_a_dir[i] <= w_dir[i];
            end
        end
    end

    // Take magnitudes and signs for the dividers
    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            w_nlo[i]     = mag(r_a_dlo[i]);
            w_nhi[i]     = mag(r_a_dhi[i]);
            w_sb[i].zero = (r_a_dir[i] == '0);
            w_sb[i].dneg = r_a_dir[i][DW-1];
            w_sb[i].nlo  = r_a_dlo[i][DW];
            w_sb[i].nhi  = r_a_dhi[i][DW];
            w_sb[i].slo  = sat_diff(r_a_dlo[i]);
            w_sb[i].shi  = sat_diff(r_a_dhi[i]);
            w_den[i]     = w_sb[i].zero ? {{(DW-1){1'b0}}, 1'b1}
                                        : mag({r_a_dir[i][DW-1], r_a_dir[i]});
        end
    end

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
        rbs_div u_div_lo (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (w_nlo[g]),
            .i_den (w_den[g]),
            .o_quo (w_qlo[g]),
            .o_ovf (w_olo[g])
        );
        rbs_div u_div_hi (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (w_nhi[g]),
            .i_den (w_den[g]),
            .o_quo (w_qhi[g]),
            .o_ovf (w_ohi[g])
        );
    end

    // Carry side information alongside the divider stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_sb[0][i] <= w_sb[i];
                for (int k = 1; k <= DW; k++) r_sb[k][i] <= r_sb[k-1][i];
            end
        end
    end

    // Stage P: sign, saturate and order the slab distances
    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            if (r_sb[DW][i].zero) begin
                n_ta[i] = r_sb[DW][i].slo;
                n_tb[i] = r_sb[DW][i].shi;
            end else if (r_sb[DW][i].dneg) begin
                n_ta[i] = sign_quo(w_qhi[i], w_ohi[i], r_sb[DW][i].nhi ^ 1'b1);
                n_tb[i] = sign_quo(w_qlo[i], w_olo[i], r_sb[DW][i].nlo ^ 1'b1);
            end else begin
                n_ta[i] = sign_quo(w_qlo[i], w_olo[i], r_sb[DW][i].nlo);
                n_tb[i] = sign_quo(w_qhi[i], w_ohi[i], r_sb[DW][i].nhi);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_ta[i] <= n_ta[i];
                r_tb[i] <= n_tb[i];
            end
        end
    end

    // Combine axes: largest entry, smallest exit
    always_comb begin
        n_near = r_ta[0];
        n_far  = r_tb[0];
        for (int i = 1; i < NUM_AXES; i++) begin
            if (r_ta[i] > n_near) n_near = r_ta[i];
            if (r_tb[i] < n_far)  n_far  = r_tb[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_near <= n_near;
            r_o_far  <= n_far;
            r_o_hit  <= (n_far >= n_near) && !n_far[DW-1];
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            for (int k = 0; k <= DW; k++) r_d_vld[k] <= 1'b0;
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld    <= i_ray.valid;
            r_d_vld[0] <= r_a_vld;
            for (int k = 1; k <= DW; k++) r_d_vld[k] <= r_d_vld[k-1];
            r_p_vld    <= r_d_vld[DW];
            r_o_vld    <= r_p_vld;
        end
    end

    assign o_res.valid  = r_o_vld;
    assign o_res.hit    = r_o_hit;
    assign o_res.t_near = r_o_near;
    assign o_res.t_far  = r_o_far;

endmodule

>>> rtl/rbs_div.sv
// Pipelined unsigned fixed-point divider: one quotient bit per stage, overflow flag.
module rbs_div
    import rbs_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [DW-1:0] o_quo,
    output logic          o_ovf
);

    logic [DW-1:0] r_rem [0:DW];
    logic [DW-1:0] r_nq  [0:DW];
    logic [DW-1:0] r_den [0:DW];
    logic          r_ovf [0:DW];

    logic [DW-1:0] n_rem [1:DW];
    logic [DW-1:0] n_nq  [1:DW];
    logic [DW-1:0] w_top;
    logic [DW:0]   w_trial [1:DW];

    // Upper part of the shifted numerator seeds the remainder
    assign w_top = {{(DW-FRAC_BITS){1'b0}}, i_num[DW-1:DW-FRAC_BITS]};

    // One restoring step per stage
    always_comb begin
        for (int k = 1; k <= DW; k++) begin
            w_trial[k] = {r_rem[k-1], r_nq[k-1][DW-1]} - {1'b0, r_den[k-1]};
            if (!w_trial[k][DW]) begin
                n_rem[k] = w_trial[k][DW-1:0];
                n_nq[k]  = {r_nq[k-1][DW-2:0], 1'b1};
            end else begin
                n_rem[k] = {r_rem[k-1][DW-2:0], r_nq[k-1][DW-1]};
                n_nq[k]  = {r_nq[k-1][DW-2:0], 1'b0};
            end
        end
    end

    // Load and advance the stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_top;
            r_nq[0]  <= {i_num[DW-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
            r_den[0] <= i_den;
            r_ovf[0] <= (w_top >= i_den);
            for (int k = 1; k <= DW; k++) begin
                r_rem[k] <= n_rem[k];
                r_nq[k]  <= n_nq[k];
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quo = r_nq[DW];
    assign o_ovf = r_ovf[DW];

endmodule

>>> bench/tb_ray_box_slab_intersection.sv
// Testbench: ray/box slab test checked against a bit-true predictor under random flow control.
`timescale 1ns / 100ps
module tb_ray_box_slab_intersection;
    import rbs_pkg::*;

    logic i_clk;
    logic i_rst_n;

    rbs_cfg_if cfg_if ();
    rbs_ray_if ray_if ();
    rbs_res_if res_if ();

    ray_box_slab_intersection u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if.sink),
        .i_ray   (ray_if.sink),
        .o_res   (res_if.source)
    );

    typedef struct packed {
        logic signed [DW-1:0] ox, oy, oz, dx, dy, dz;
    } t_ray;

    typedef struct packed {
        logic                 hit;
        logic signed [DW-1:0] t_near;
        logic signed [DW-1:0] t_far;
    } t_hit;

    typedef struct {
        t_ray ray;
        logic chk;
        t_hit res;
    } t_row;

    // Box as seen by the predictor
    logic signed [DW-1:0] box_lo [NUM_AXES];
    logic signed [DW-1:0] box_hi [NUM_AXES];

    t_hit hit_q [$];
    int   n_err;
    int   n_rays;
    int   n_res;
    int   n_hits;
    bit   calm;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Fixed-point quotient, truncated toward zero and saturated
    function automatic logic signed [DW-1:0] slab_div(longint num, longint den);
        logic   neg;
        longint n, d;
        longint q;
        neg = (num < 0) != (den < 0);
        n   = (num < 0) ? -num : num;
        d   = (den < 0) ? -den : den;
        q   = (n <<< FRAC_BITS) / d;
        if (neg) begin
            if (q > 64'sd2147483648) return S32_MIN;
            return DW'(-q);
        end
        if (q > 64'sd2147483647) return S32_MAX;
        return DW'(q);
    endfunction

    function automatic logic signed [DW-1:0] clip32(longint v);
        if (v > 64'sd2147483647) return S32_MAX;
        if (v < -64'sd2147483648) return S32_MIN;
        return DW'(v);
    endfunction

    function automatic t_hit slab_test(t_ray r);
        t_hit   h;
        longint org [NUM_AXES];
        longint dr  [NUM_AXES];
        longint lo, hi;
        logic signed [DW-1:0] ta, tb, tt;
        org = '{longint'(r.ox), longint'(r.oy), longint'(r.oz)};
        dr  = '{longint'(r.dx), longint'(r.dy), longint'(r.dz)};
        for (int a = 0; a < NUM_AXES; a++) begin
            lo = longint'(box_lo[a]) - org[a];
            hi = longint'(box_hi[a]) - org[a];
            if (dr[a] == 0) begin
                ta = clip32(lo);
                tb = clip32(hi);
            end else begin
                ta = slab_div(lo, dr[a]);
                tb = slab_div(hi, dr[a]);
                if (dr[a] < 0) begin
                    tt = ta;
                    ta = tb;
                    tb = tt;
                end
            end
            if (a == 0 || ta > h.t_near) h.t_near = ta;
            if (a == 0 || tb < h.t_far) h.t_far = tb;
        end
        h.hit = (h.t_far >= h.t_near) && (h.t_far >= 0);
        return h;
    endfunction

    // Drop valid for a random idle burst
    task automatic gap_burst();
        if (!calm && $urandom_range(0, 5) == 0) begin
            ray_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(t_reg_idx idx, logic [DW-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        if (idx < NUM_AXES) box_lo[idx] = val;
        else box_hi[idx - NUM_AXES] = val;
        @(negedge i_clk);
    endtask

    task automatic load_box(logic [DW-1:0] lx, ly, lz, hx, hy, hz);
        write_reg(REG_MIN_X, lx);
        write_reg(REG_MIN_Y, ly);
        write_reg(REG_MIN_Z, lz);
        write_reg(REG_MAX_X, hx);
        write_reg(REG_MAX_Y, hy);
        write_reg(REG_MAX_Z, hz);
        cfg_if.valid <= 1'b0;
    endtask

    // Wait for every result, then let the pipe drain
    task automatic drain_pipe();
        ray_if.valid <= 1'b0;
        while (hit_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    // Send one item; expectation queued at the accepting edge, valid held for the next
    task automatic send_ray(t_ray r, logic chk, t_hit res);
        gap_burst();
        ray_if.valid    <= 1'b1;
        ray_if.origin_x <= r.ox;
        ray_if.origin_y <= r.oy;
        ray_if.origin_z <= r.oz;
        ray_if.dir_x    <= r.dx;
        ray_if.dir_y    <= r.dy;
        ray_if.dir_z    <= r.dz;
        @(posedge i_clk);
        while (!ray_if.ready) @(posedge i_clk);
        if (chk) begin
            if (res !== slab_test(r)) begin
                $error("table row disagrees with predictor");
                n_err++;
            end
        end
        hit_q.push_back(slab_test(r));
        n_rays++;
        @(negedge i_clk);
    endtask

    function automatic logic [DW-1:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return S32_MAX;
            1: return S32_MIN;
            2: return 32'd0;
            3: return $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : 32'd1;
            4: return DW'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DW-1:0] rnd_dir();
        if ($urandom_range(0, 9) == 0) return 32'd0;
        if ($urandom_range(0, 2) == 0) return $urandom;
        return DW'($signed($urandom_range(1, 32'h0004_0000)) * ($urandom_range(0, 1) ? 1 : -1));
    endfunction

    // Receive side: random stall, compare against the oldest expectation
    always @(negedge i_clk) begin
        if (!i_rst_n) res_if.ready <= 1'b0;
        else res_if.ready <= calm || ($urandom_range(0, 5) != 0);
    end

    always @(posedge i_clk) begin
        t_hit want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (hit_q.size() == 0) begin
                $error("result item with nothing expected");
                n_err++;
            end else begin
                want = hit_q.pop_front();
                n_res++;
                if (res_if.hit) n_hits++;
                if (res_if.hit !== want.hit) begin
                    $error("hit: expected %0d actual %0d", want.hit, res_if.hit);
                    n_err++;
                end
                if (res_if.t_near !== want.t_near) begin
                    $error("t_near: expected %0d actual %0d", want.t_near, res_if.t_near);
                    n_err++;
                end
                if (res_if.t_far !== want.t_far) begin
                    $error("t_far: expected %0d actual %0d", want.t_far, res_if.t_far);
                    n_err++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    initial begin
        t_row rows [$];
        t_ray r;
        t_hit none;
        none = '0;
        n_err  = 0;
        n_rays = 0;
        n_res  = 0;
        n_hits = 0;
        calm   = 1'b0;
        i_rst_n = 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= '0;
        cfg_if.data  <= '0;
        ray_if.valid <= 1'b0;
        {ray_if.origin_x, ray_if.origin_y, ray_if.origin_z} <= '0;
        {ray_if.dir_x, ray_if.dir_y, ray_if.dir_z} <= '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            box_lo[a] = S32_MAX;
            box_hi[a] = S32_MIN;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // After reset the box is empty: zero direction gives clipped differences
        rows.push_back('{'{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b1,
                         '{1'b0, S32_MAX, S32_MIN}});
        rows.push_back('{'{S32_MIN, S32_MIN, S32_MIN, 32'd0, 32'd0, 32'd0}, 1'b1,
                         '{1'b0, S32_MAX, 32'd0}});
        rows.push_back('{'{S32_MAX, S32_MAX, S32_MAX, 32'd0, 32'd0, 32'd0}, 1'b1,
                         '{1'b0, 32'd0, S32_MIN}});
        rows.push_back('{'{32'd0, 32'd0, 32'd0, S32_MIN, S32_MIN, S32_MIN}, 1'b0, none});
        rows.push_back('{'{32'd0, 32'd0, 32'd0, S32_MAX, 32'd1, 32'hFFFF_FFFF}, 1'b0, none});
        foreach (rows[k]) send_ray(rows[k].ray, rows[k].chk, rows[k].res);
        drain_pipe();

        // Unit box around origin: forward, backward, axis-parallel, inside, outside
        load_box(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
                 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        rows.delete();
        rows.push_back('{'{32'hFFFB_0000, 32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd0}, 1'b0, none});
        rows.push_back('{'{32'h0005_0000, 32'd0, 32'd0, 32'hFFFF_0000, 32'd0, 32'd0}, 1'b0, none});
        rows.push_back('{'{32'd0, 32'd0, 32'd0, 32'h0000_4000, 32'h0001_0000, 32'hFFFF_8000},
                         1'b0, none});
        rows.push_back('{'{32'h0005_0000, 32'h0005_0000, 32'd0, 32'h0001_0000, 32'd0, 32'd0},
                         1'b0, none});
        rows.push_back('{'{32'd0, 32'd0, 32'd0, 32'd1, 32'd1, 32'd1}, 1'b0, none});
        rows.push_back('{'{S32_MAX, S32_MIN, 32'd0, 32'hFFFF_FFFF, 32'd1, S32_MIN}, 1'b0, none});
        rows.push_back('{'{32'hFFFE_0000, 32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd0}, 1'b0, none});
        foreach (rows[k]) send_ray(rows[k].ray, rows[k].chk, rows[k].res);
        drain_pipe();

        // Extreme and inverted box
        load_box(S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX);
        rows.delete();
        rows.push_back('{'{S32_MAX, S32_MIN, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd0}, 1'b0, none});
        rows.push_back('{'{S32_MIN, S32_MAX, 32'd0, S32_MIN, S32_MAX, 32'd1}, 1'b0, none});
        foreach (rows[k]) send_ray(rows[k].ray, rows[k].chk, rows[k].res);
        drain_pipe();
        load_box(32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 32'hFFFE_0000, 32'hFFFE_0000,
                 32'hFFFE_0000);
        r = '{32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
        send_ray(r, 1'b0, none);
        drain_pipe();

        // Random phases, each with its own box
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 10) calm = 1'b1;
            if (ph % 4 == 3) load_box(rnd_word(), rnd_word(), rnd_word(),
                                      rnd_word(), rnd_word(), rnd_word());
            else begin
                logic signed [DW-1:0] c [NUM_AXES];
                logic signed [DW-1:0] w [NUM_AXES];
                for (int a = 0; a < NUM_AXES; a++) begin
                    c[a] = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
                    w[a] = $urandom_range(1, 32'h0010_0000);
                end
                load_box(c[0] - w[0], c[1] - w[1], c[2] - w[2],
                         c[0] + w[0], c[1] + w[1], c[2] + w[2]);
            end
            for (int k = 0; k < 150; k++) begin
                if ($urandom_range(0, 2) != 0) begin
                    // Aim near the box from a point around it
                    r.ox = box_lo[0] + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
                    r.oy = box_lo[1] + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
                    r.oz = box_hi[2] + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
                    r.dx = rnd_dir();
                    r.dy = rnd_dir();
                    r.dz = rnd_dir();
                end else begin
                    r = '{rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word()};
                end
                send_ray(r, 1'b0, none);
                // Hold off until the pipe has emptied once
                if (ph == 2 && k == 70) begin
                    ray_if.valid <= 1'b0;
                    while (hit_q.size() != 0) @(negedge i_clk);
                end
            end
            drain_pipe();
        end

        $display("Sent %0d rays over directed and 12 random box settings; %0d results, %0d hits.",
                 n_rays, n_res, n_hits);
        if (n_err == 0 && hit_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/rbs_pkg.sv
rtl/rbs_if.sv
rtl/rbs_div.sv
rtl/ray_box_slab_intersection.sv
bench/tb_ray_box_slab_intersection.sv
